// File: src/jsu_pkg.sv
// Shared types, codes and character helpers for the JSON string unescaper.
package jsu_pkg;

    localparam int RES_MAX = 4;
    localparam int CNT_W   = $clog2(RES_MAX + 1);
    localparam int IDX_W   = $clog2(RES_MAX);

    localparam logic [1:0] K_BYTE  = 2'd0;
    localparam logic [1:0] K_CLOSE = 2'd1;
    localparam logic [1:0] K_ERR   = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [15:0] UTF8_MAX1 = 16'h007F;
    localparam logic [15:0] UTF8_MAX2 = 16'h07FF;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_STR  = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        t_result [RES_MAX-1:0]     res;
    } t_bundle;

    // Bit 4 is set when the byte is a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] simple_escape(input logic [7:0] e);
        logic [7:0] r;
        unique case (e)
            CH_QUOTE:  r = CH_QUOTE;
            CH_BSLASH: r = CH_BSLASH;
            CH_SLASH:  r = CH_SLASH;
            8'h62:     r = 8'h08;
            8'h66:     r = 8'h0C;
            8'h6E:     r = 8'h0A;
            8'h72:     r = 8'h0D;
            8'h74:     r = 8'h09;
            default:   r = CH_QMARK;
        endcase
        return r;
    endfunction

endpackage

// File: src/jsu_decode.sv
// Input register, string state and per-byte decode into a bundle of results.
module jsu_decode import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_string_start,
    input  logic       i_text_end,
    output logic       o_bnd_valid,
    input  logic       i_bnd_ready,
    output t_bundle    o_bnd
);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_start;
    logic        r_end;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hex_left, n_hex_left;
    logic [15:0] r_code, n_code;

    logic [4:0]            hex;
    logic [15:0]           code_next;
    t_result [RES_MAX-1:0] res;
    logic [CNT_W-1:0]      cnt;
    logic                  step;

    assign o_ready     = !r_in_valid || i_bnd_ready;
    assign o_bnd_valid = r_in_valid;
    assign step        = r_in_valid && i_bnd_ready;
    assign hex         = hex_val(r_byte);
    assign code_next   = {r_code[11:0], hex[3:0]};
    assign o_bnd.cnt   = cnt;
    assign o_bnd.res   = res;

    always_comb begin
        n_phase    = r_phase;
        n_hex_left = r_hex_left;
        n_code     = r_code;
        res        = '0;
        cnt        = '0;
        if (r_start) begin
            n_hex_left = 3'd0;
            n_code     = 16'd0;
            if (r_byte != CH_QUOTE) begin
                n_phase = PH_IDLE;
                res[0]  = '{kind: K_ERR, data: 8'h00};
                cnt     = CNT_W'(1);
            end else begin
                n_phase = PH_STR;
            end
        end else begin
            unique case (r_phase)
                PH_STR: begin
                    if (r_byte == CH_QUOTE) begin
                        n_phase = PH_IDLE;
                        res[0]  = '{kind: K_CLOSE, data: 8'h00};
                        cnt     = CNT_W'(1);
                    end else if (r_byte == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        res[0] = '{kind: K_BYTE, data: r_byte};
                        cnt    = CNT_W'(1);
                    end
                end
                PH_ESC: begin
                    if (r_byte == CH_U) begin
                        n_phase    = PH_HEX;
                        n_hex_left = 3'd4;
                        n_code     = 16'd0;
                    end else begin
                        n_phase = PH_STR;
                        res[0]  = '{kind: K_BYTE, data: simple_escape(r_byte)};
                        cnt     = CNT_W'(1);
                    end
                end
                PH_HEX: begin
                    if (!hex[4]) begin
                        n_phase    = PH_STR;
                        n_hex_left = 3'd0;
                        res[0]     = '{kind: K_BYTE, data: CH_QMARK};
                        cnt        = CNT_W'(1);
                    end else begin
                        n_code = code_next;
                        if (r_hex_left <= 3'd1) begin
                            n_phase    = PH_STR;
                            n_hex_left = 3'd0;
                            if (code_next <= UTF8_MAX1) begin
                                res[0] = '{kind: K_BYTE, data: code_next[7:0]};
                                cnt    = CNT_W'(1);
                            end else if (code_next <= UTF8_MAX2) begin
                                res[0] = '{kind: K_BYTE,
                                           data: UTF8_LEAD2 | {3'b000, code_next[10:6]}};
                                res[1] = '{kind: K_BYTE,
                                           data: UTF8_CONT | {2'b00, code_next[5:0]}};
                                cnt    = CNT_W'(2);
                            end else begin
                                res[0] = '{kind: K_BYTE,
                                           data: UTF8_LEAD3 | {4'b0000, code_next[15:12]}};
                                res[1] = '{kind: K_BYTE,
                                           data: UTF8_CONT | {2'b00, code_next[11:6]}};
                                res[2] = '{kind: K_BYTE,
                                           data: UTF8_CONT | {2'b00, code_next[5:0]}};
                                cnt    = CNT_W'(3);
                            end
                        end else begin
                            n_hex_left = r_hex_left - 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (r_end && n_phase != PH_IDLE) begin
            if (n_phase == PH_HEX) begin
                res[0] = '{kind: K_BYTE, data: CH_QMARK};
                res[1] = '{kind: K_ERR, data: 8'h00};
                cnt    = CNT_W'(2);
            end else begin
                res[cnt[IDX_W-1:0]] = '{kind: K_ERR, data: 8'h00};
                cnt = cnt + CNT_W'(1);
            end
            n_phase    = PH_IDLE;
            n_hex_left = 3'd0;
            n_code     = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_hex_left <= 3'd0;
            r_code     <= 16'd0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (step) begin
                r_phase    <= n_phase;
                r_hex_left <= n_hex_left;
                r_code     <= n_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte  <= i_text_byte;
            r_start <= i_string_start;
            r_end   <= i_text_end;
        end
    end

`ifndef SYNTH
    a_hex_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEX) |-> (r_hex_left != 3'd0 && r_hex_left <= 3'd4))
        else $error("hex digit count out of range inside a unicode escape");

    a_hex_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEX) |-> (r_hex_left == 3'd0))
        else $error("hex digit count left over outside a unicode escape");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_end) |=> (r_phase == PH_IDLE))
        else $error("string still open after the last text byte");
`endif

endmodule

// File: src/jsu_emit.sv
// Result register that holds one bundle and sends its words out one per cycle.
module jsu_emit import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_bnd_valid,
    output logic       o_bnd_ready,
    input  t_bundle    i_bnd,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic [CNT_W-1:0]      r_left;
    t_result [RES_MAX-1:0] r_res;
    logic                  load;
    logic                  send;

    assign o_valid     = (r_left != '0);
    assign o_last      = (r_left == CNT_W'(1));
    assign o_kind      = r_res[0].kind;
    assign o_out_byte  = r_res[0].data;
    assign send        = o_valid && i_ready;
    assign o_bnd_ready = (r_left == '0) || (o_last && i_ready);
    assign load        = i_bnd_valid && o_bnd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= i_bnd.cnt;
        end else if (send) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_bnd.res;
        end else if (send) begin
            for (int i = 0; i < RES_MAX - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
            r_res[RES_MAX-1] <= '0;
        end
    end

`ifndef SYNTH
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CNT_W'(RES_MAX))
        else $error("result count exceeds the bundle size");

    a_burst_goes_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (send && !o_last) |=> o_valid)
        else $error("bundle dropped before its last word");

    a_empty_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_bnd.cnt == '0) |=> !o_valid)
        else $error("word shown for an item that has no result");
`endif

endmodule

// File: src/json_string_unescape.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// The input channel (i_valid / o_ready) takes one word per cycle while
// o_ready is high: a JSON text byte, a flag that marks the opening quote
// of a string and a flag that marks the last byte of available text.
// The output channel (o_valid / i_ready) gives one word per cycle while
// i_ready is high: a kind (decoded byte, string closed, or error), the
// decoded byte and a flag on the final word caused by each input byte.
// An accepted byte is held in the input register while it is decoded;
// its results are then loaded into the result register, which shows its
// first result word. A byte with at most one result lets a new byte in
// every cycle while the receiver takes each word.
// A byte with k results (up to four, from a unicode escape that ends the
// text) holds the result register until its last word is sent, as the single
// output port sends one word per cycle while i_ready is high.
// When the receiver stalls, the result register holds its word and the
// input register holds the next byte; o_ready falls until space frees.
// A synchronous active-low reset closes any open string and empties both
// registers; no word is shown until new bytes arrive.
module json_string_unescape import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_string_start,
    input  logic       i_text_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic    bnd_valid;
    logic    bnd_ready;
    t_bundle bnd;

    jsu_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .i_string_start (i_string_start),
        .i_text_end     (i_text_end),
        .o_bnd_valid    (bnd_valid),
        .i_bnd_ready    (bnd_ready),
        .o_bnd          (bnd)
    );

    jsu_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bnd_valid (bnd_valid),
        .o_bnd_ready (bnd_ready),
        .i_bnd       (bnd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

// File: tb/json_string_unescape_tb.sv
// Testbench for the JSON string unescaper: directed table, random strings, checked by a predictor.
`timescale 1ns / 100ps

module json_string_unescape_tb;
    import jsu_pkg::*;

    localparam int N_DIR       = 34;
    localparam int RAND_WORDS  = 480;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_decoded;

    typedef struct packed {
        logic [7:0] b;
        logic       s;
        logic       e;
        logic       typed;
        logic       has_word;
        logic [1:0] kind;
        logic [7:0] data;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_string_start = 1'b0;
    logic       i_text_end = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic       o_last;

    json_string_unescape i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .i_string_start (i_string_start),
        .i_text_end     (i_text_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_phase      str_phase = PH_IDLE;
    logic [2:0]  hex_left = 3'd0;
    logic [15:0] code_value = 16'd0;
    t_decoded    step_words [RES_MAX];
    int          step_n;

    t_decoded    decoded_q [$];
    t_decoded    want;
    t_stim_row   dir_rows [N_DIR];

    int cycle_cnt = 0;
    int err_cnt = 0;
    int words_checked = 0;
    int sent_words = 0;
    int live_words = 0;
    int strings_sent = 0;
    int uni_count = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int rx_tick = 0;

    function automatic void emit(input logic [1:0] kind, input logic [7:0] data);
        step_words[step_n] = {kind, data, 1'b0};
        step_n++;
    endfunction

    function automatic void emit_utf8(input logic [15:0] v);
        if (v <= UTF8_MAX1) begin
            emit(K_BYTE, v[7:0]);
        end else if (v <= UTF8_MAX2) begin
            emit(K_BYTE, UTF8_LEAD2 | {3'b000, v[10:6]});
            emit(K_BYTE, UTF8_CONT | {2'b00, v[5:0]});
        end else begin
            emit(K_BYTE, UTF8_LEAD3 | {4'h0, v[15:12]});
            emit(K_BYTE, UTF8_CONT | {2'b00, v[11:6]});
            emit(K_BYTE, UTF8_CONT | {2'b00, v[5:0]});
        end
    endfunction

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] escape_char(input logic [7:0] c);
        case (c) inside
            CH_QUOTE, CH_BSLASH, CH_SLASH: return c;
            "b": return 8'h08;
            "f": return 8'h0C;
            "n": return 8'h0A;
            "r": return 8'h0D;
            "t": return 8'h09;
            default: return CH_QMARK;
        endcase
    endfunction

    function automatic void unescape_step(input logic [7:0] b, input logic s, input logic e);
        logic [3:0] nib;
        step_n = 0;
        if (s) begin
            hex_left = 3'd0;
            code_value = 16'd0;
            if (b != CH_QUOTE) begin
                str_phase = PH_IDLE;
                emit(K_ERR, 8'h00);
            end else begin
                str_phase = PH_STR;
            end
        end else begin
            case (str_phase)
                PH_STR: begin
                    if (b == CH_QUOTE) begin
                        str_phase = PH_IDLE;
                        emit(K_CLOSE, 8'h00);
                    end else if (b == CH_BSLASH) begin
                        str_phase = PH_ESC;
                    end else begin
                        emit(K_BYTE, b);
                    end
                end
                PH_ESC: begin
                    if (b == CH_U) begin
                        str_phase = PH_HEX;
                        hex_left = 3'd4;
                        code_value = 16'd0;
                    end else begin
                        str_phase = PH_STR;
                        emit(K_BYTE, escape_char(b));
                    end
                end
                PH_HEX: begin
                    if (!hex_nibble(b, nib)) begin
                        str_phase = PH_STR;
                        hex_left = 3'd0;
                        emit(K_BYTE, CH_QMARK);
                    end else begin
                        code_value = {code_value[11:0], nib};
                        if (hex_left <= 3'd1) begin
                            str_phase = PH_STR;
                            hex_left = 3'd0;
                            emit_utf8(code_value);
                        end else begin
                            hex_left = hex_left - 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (e && str_phase != PH_IDLE) begin
            if (str_phase == PH_HEX) emit(K_BYTE, CH_QMARK);
            emit(K_ERR, 8'h00);
            str_phase = PH_IDLE;
            hex_left = 3'd0;
            code_value = 16'd0;
        end
        if (step_n > 0) step_words[step_n - 1].last = 1'b1;
    endfunction

    task automatic drive_word(input logic [7:0] b, input logic s, input logic e,
                              input logic typed = 1'b0, input logic has_word = 1'b0,
                              input logic [1:0] tkind = K_BYTE,
                              input logic [7:0] tdata = 8'h00);
        int gap;
        int k;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 2);
                2: gap = $urandom_range(1, 6);
                default: gap = $urandom_range(8, 20);
            endcase
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_text_byte <= b;
        i_string_start <= s;
        i_text_end <= e;
        sent_words++;
        if (s || str_phase != PH_IDLE) live_words++;
        unescape_step(b, s, e);
        if (typed) begin
            if (has_word) decoded_q.insert(decoded_q.size(), {tkind, tdata, 1'b1});
        end else begin
            for (k = 0; k < step_n; k++) decoded_q.insert(decoded_q.size(), step_words[k]);
        end
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_random_string();
        logic [7:0]  txt [$];
        logic [7:0]  c;
        logic [15:0] cp;
        logic [3:0]  nib;
        int pieces, p, k, n_hex, mode, cut;
        txt.insert(txt.size(), CH_QUOTE);
        pieces = $urandom_range(0, 10);
        for (p = 0; p < pieces; p++) begin
            case ($urandom_range(0, 9)) inside
                [5:6]: begin
                    txt.insert(txt.size(), CH_BSLASH);
                    if ($urandom_range(0, 4) == 0) begin
                        txt.insert(txt.size(), 8'($urandom));
                    end else begin
                        case ($urandom_range(0, 7))
                            0: txt.insert(txt.size(), CH_QUOTE);
                            1: txt.insert(txt.size(), CH_BSLASH);
                            2: txt.insert(txt.size(), CH_SLASH);
                            3: txt.insert(txt.size(), "b");
                            4: txt.insert(txt.size(), "f");
                            5: txt.insert(txt.size(), "n");
                            6: txt.insert(txt.size(), "r");
                            default: txt.insert(txt.size(), "t");
                        endcase
                    end
                end
                [7:9]: begin
                    case ($urandom_range(0, 3))
                        0: cp = 16'($urandom_range(0, 16'h007F));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                        default: begin
                            case ($urandom_range(0, 5))
                                0: cp = 16'h0000;
                                1: cp = 16'h007F;
                                2: cp = 16'h0080;
                                3: cp = 16'h07FF;
                                4: cp = 16'h0800;
                                default: cp = 16'hFFFF;
                            endcase
                        end
                    endcase
                    n_hex = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
                    txt.insert(txt.size(), CH_BSLASH);
                    txt.insert(txt.size(), CH_U);
                    for (k = 3; k > 3 - n_hex; k--) begin
                        nib = cp[k*4 +: 4];
                        if (nib < 4'd10) c = "0" + {4'h0, nib};
                        else if ($urandom_range(0, 1) == 0) c = "A" + {4'h0, nib} - 8'd10;
                        else c = "a" + {4'h0, nib} - 8'd10;
                        txt.insert(txt.size(), c);
                    end
                    if (n_hex < 4) begin
                        do c = 8'($urandom); while (hex_nibble(c, nib));
                        txt.insert(txt.size(), c);
                    end else begin
                        uni_count++;
                    end
                end
                default: begin
                    do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
                    txt.insert(txt.size(), c);
                end
            endcase
        end
        txt.insert(txt.size(), CH_QUOTE);
        strings_sent++;
        mode = $urandom_range(0, 19);
        if (mode < 14) begin
            for (k = 0; k < txt.size(); k++)
                drive_word(txt[k], k == 0,
                           (k == txt.size() - 1) && ($urandom_range(0, 5) == 0));
        end else begin
            cut = $urandom_range(0, txt.size() - 2);
            for (k = 0; k <= cut; k++)
                drive_word(txt[k], k == 0, (k == cut) && (mode < 17));
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 200);
        end
        stall_left--;
        rx_tick++;
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= ((rx_tick % 5) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles, %0d words still expected",
                     $time, cycle_cnt, decoded_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, %s kind=%0d byte=%02h last=%0b",
                         $time, "actual", o_kind, o_out_byte, o_last);
                err_cnt++;
            end else begin
                want = decoded_q.pop_front();
                words_checked++;
                if (o_kind !== want.kind || o_out_byte !== want.data
                        || o_last !== want.last) begin
                    $display("%0t: mismatch, expected kind=%0d byte=%02h last=%0b,",
                             $time, want.kind, want.data, want.last);
                    $display("%0t:           actual kind=%0d byte=%02h last=%0b",
                             $time, o_kind, o_out_byte, o_last);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        int r, mark, n_noise, k;
        logic [7:0] c;
        bit pressed;
        dir_rows = '{
            '{8'h41,     1'b0, 1'b0, 1'b1, 1'b0, K_BYTE,  8'h00},
            '{8'h41,     1'b1, 1'b0, 1'b1, 1'b1, K_ERR,   8'h00},
            '{CH_QUOTE,  1'b1, 1'b0, 1'b1, 1'b0, K_BYTE,  8'h00},
            '{8'h00,     1'b0, 1'b0, 1'b1, 1'b1, K_BYTE,  8'h00},
            '{8'hFF,     1'b0, 1'b0, 1'b1, 1'b1, K_BYTE,  8'hFF},
            '{CH_BSLASH, 1'b0, 1'b0, 1'b1, 1'b0, K_BYTE,  8'h00},
            '{"t",       1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"0",       1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"7",       1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"f",       1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"F",       1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"z",       1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_QUOTE,  1'b0, 1'b0, 1'b1, 1'b1, K_CLOSE, 8'h00},
            '{CH_QUOTE,  1'b1, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_U,      1'b0, 1'b1, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_QUOTE,  1'b1, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_BSLASH, 1'b0, 1'b1, 1'b1, 1'b1, K_ERR,   8'h00},
            '{CH_QUOTE,  1'b1, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_QUOTE,  1'b1, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"b",       1'b0, 1'b1, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_QUOTE,  1'b1, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_BSLASH, 1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_U,      1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"E",       1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"0",       1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"a",       1'b0, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{"9",       1'b0, 1'b1, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_QUOTE,  1'b1, 1'b0, 1'b0, 1'b0, K_BYTE,  8'h00},
            '{CH_QUOTE,  1'b0, 1'b1, 1'b1, 1'b1, K_CLOSE, 8'h00}
        };
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIR; r++)
            drive_word(dir_rows[r].b, dir_rows[r].s, dir_rows[r].e, dir_rows[r].typed,
                       dir_rows[r].has_word, dir_rows[r].kind, dir_rows[r].data);

        mark = live_words;
        pressed = 1'b0;
        while (live_words < mark + RAND_WORDS) begin
            if (!pressed && live_words >= mark + RAND_WORDS / 2) begin
                wait_drained();
                pressed = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                n_noise = $urandom_range(1, 8);
                for (k = 0; k < n_noise; k++) begin
                    c = ($urandom_range(0, 3) == 0) ? CH_QUOTE : 8'($urandom);
                    drive_word(c, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
                end
            end else begin
                send_random_string();
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d input words (%0d inside strings), %0d random strings,",
                 sent_words, live_words, strings_sent);
        $display("%0d unicode escapes; checked %0d output words in %0d cycles, %0d mismatches.",
                 uni_count, words_checked, cycle_cnt, err_cnt);
        if (err_cnt == 0 && decoded_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
